### design/ezvr_pkg.sv
package ezvr_pkg;

  localparam int VectorWidthDef = 32;
  localparam int AngleWidthDef  = 16;

  localparam int CordicFrac   = 54;
  localparam int CordicStages = 54;
  localparam int CordicW      = CordicFrac + 3;
  localparam int AngleAccW    = CordicFrac + 2;
  localparam int CoefW        = 17;

  localparam real InvHalfPi = 0.5 / $atan(1.0);

  typedef logic signed [CordicW-1:0]   cw_t;
  typedef logic signed [AngleAccW-1:0] zw_t;
  typedef logic signed [CoefW-1:0]     coef_t;

  function automatic zw_t atan_const(input int idx);
    real v;
    v = $atan(2.0 ** (-idx)) * InvHalfPi * (2.0 ** CordicFrac);
    return zw_t'(longint'(v));
  endfunction

  function automatic cw_t cordic_gain();
    real k;
    k = 1.0;
    for (int i = 0; i < CordicStages; i++) begin
      k = k * ((1.0 + 2.0 ** (-2 * i)) ** (-0.5));
    end
    return cw_t'(longint'(k * (2.0 ** CordicFrac)));
  endfunction

endpackage

### design/ezvr_cordic_cell.sv
module ezvr_cordic_cell
  import ezvr_pkg::*;
#(
  parameter int Idx = 0
) (
  input  logic clk_i,
  input  logic en_i,
  input  cw_t  x_i,
  input  cw_t  y_i,
  input  zw_t  z_i,
  output cw_t  x_o,
  output cw_t  y_o,
  output zw_t  z_o
);

  localparam zw_t Atan = atan_const(Idx);

  cw_t x_d, y_d, x_q, y_q;
  zw_t z_d, z_q;
  cw_t xs, ys;

  always_comb begin
    xs = x_i >>> Idx;
    ys = y_i >>> Idx;
    if (!z_i[AngleAccW-1]) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - Atan;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + Atan;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

### design/ezvr_rot_stage.sv
module ezvr_rot_stage
  import ezvr_pkg::*;
#(
  parameter int VectorWidth = VectorWidthDef,
  parameter int SideWidth   = VectorWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [VectorWidth-1:0] a_i,
  input  logic signed [VectorWidth-1:0] b_i,
  input  coef_t                         c_i,
  input  coef_t                         s_i,
  input  logic [SideWidth-1:0]          side_i,
  output logic                          valid_o,
  output logic signed [VectorWidth-1:0] r1_o,
  output logic signed [VectorWidth-1:0] r2_o,
  output logic [SideWidth-1:0]          side_o
);

  localparam int PW = VectorWidth + CoefW;
  localparam int SW = VectorWidth + CoefW + 2;
  localparam logic signed [SW-1:0] MaxV = {{(SW-VectorWidth+1){1'b0}}, {(VectorWidth-1){1'b1}}};
  localparam logic signed [SW-1:0] MinV = {{(SW-VectorWidth+1){1'b1}}, {(VectorWidth-1){1'b0}}};
  localparam logic signed [SW-1:0] Half = SW'(1) <<< 14;

  logic signed [PW-1:0] ca_q, sb_q, sa_q, cb_q;
  logic [SideWidth-1:0] side_q, side2_q;
  logic                 v1_q, v2_q;
  logic signed [SW-1:0] t1, t2, q1, q2;
  logic signed [VectorWidth-1:0] r1_d, r2_d, r1_q, r2_q;

  function automatic logic signed [VectorWidth-1:0] sat(input logic signed [SW-1:0] v);
    if (v > MaxV) return MaxV[VectorWidth-1:0];
    if (v < MinV) return MinV[VectorWidth-1:0];
    return v[VectorWidth-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ca_q    <= PW'(c_i * a_i);
      sb_q    <= PW'(s_i * b_i);
      sa_q    <= PW'(s_i * a_i);
      cb_q    <= PW'(c_i * b_i);
      side_q  <= side_i;
      r1_q    <= r1_d;
      r2_q    <= r2_d;
      side2_q <= side_q;
    end
  end

  always_comb begin
    t1   = SW'(ca_q) - SW'(sb_q) + Half;
    t2   = SW'(sa_q) + SW'(cb_q) + Half;
    q1   = t1 >>> 15;
    q2   = t2 >>> 15;
    r1_d = sat(q1);
    r2_d = sat(q2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  assign valid_o = v2_q;
  assign r1_o    = r1_q;
  assign r2_o    = r2_q;
  assign side_o  = side2_q;

endmodule

### design/euler_zyx_vector_rotate_top.sv
// Throughput: one transaction per cycle while in_ready_o is high (skid empty); the
// sine/cosine cell chain, the coefficient register and three rotation stages, each
// with a product and a result register, advance together under one enable.
// A skid register on the output lets the chain move while a result waits.
// Reset clears all valid flags and the skid; payload registers are not reset.
module euler_zyx_vector_rotate_top
  import ezvr_pkg::*;
#(
  parameter int VectorWidth = VectorWidthDef,
  parameter int AngleWidth  = AngleWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [VectorWidth-1:0] vec_x_i,
  input  logic signed [VectorWidth-1:0] vec_y_i,
  input  logic signed [VectorWidth-1:0] vec_z_i,
  input  logic signed [AngleWidth-1:0]  yaw_angle_i,
  input  logic signed [AngleWidth-1:0]  pitch_angle_i,
  input  logic signed [AngleWidth-1:0]  roll_angle_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [VectorWidth-1:0] out_x_o,
  output logic signed [VectorWidth-1:0] out_y_o,
  output logic signed [VectorWidth-1:0] out_z_o
);

  localparam int N   = CordicStages;
  localparam int RW  = AngleWidth - 2;
  localparam int VW  = VectorWidth;
  localparam cw_t X0 = cordic_gain();

  typedef logic signed [VW-1:0] vec_t;

  logic en;

  // sine/cosine chains: lane 0 yaw, 1 pitch, 2 roll
  cw_t  cx [3][N+1];
  cw_t  cy [3][N+1];
  zw_t  cz [3][N+1];
  logic [1:0] quad_q [3][N];
  logic [1:0] quad_in [3];
  logic [RW-1:0] res_in [3];
  vec_t vx_q [N];
  vec_t vy_q [N];
  vec_t vz_q [N];
  logic [N-1:0] cv_q;

  assign quad_in[0] = yaw_angle_i[AngleWidth-1:AngleWidth-2];
  assign quad_in[1] = pitch_angle_i[AngleWidth-1:AngleWidth-2];
  assign quad_in[2] = roll_angle_i[AngleWidth-1:AngleWidth-2];
  assign res_in[0]  = yaw_angle_i[RW-1:0];
  assign res_in[1]  = pitch_angle_i[RW-1:0];
  assign res_in[2]  = roll_angle_i[RW-1:0];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    assign cx[l][0] = X0;
    assign cy[l][0] = '0;
    assign cz[l][0] = {2'b00, res_in[l], {(CordicFrac-RW){1'b0}}};
    for (genvar k = 0; k < N; k++) begin : g_cell
      ezvr_cordic_cell #(.Idx(k)) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .x_i   (cx[l][k]),
        .y_i   (cy[l][k]),
        .z_i   (cz[l][k]),
        .x_o   (cx[l][k+1]),
        .y_o   (cy[l][k+1]),
        .z_o   (cz[l][k+1])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        quad_q[l][0] <= quad_in[l];
        for (int k = 1; k < N; k++) quad_q[l][k] <= quad_q[l][k-1];
      end
      vx_q[0] <= vec_x_i;
      vy_q[0] <= vec_y_i;
      vz_q[0] <= vec_z_i;
      for (int k = 1; k < N; k++) begin
        vx_q[k] <= vx_q[k-1];
        vy_q[k] <= vy_q[k-1];
        vz_q[k] <= vz_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= '0;
    end else if (en) begin
      cv_q <= {cv_q[N-2:0], in_valid_i};
    end
  end

  // coefficient register
  function automatic coef_t rnd(input cw_t v);
    cw_t t;
    t = v + (cw_t'(1) <<< (CordicFrac - 16));
    t = t >>> (CordicFrac - 15);
    return coef_t'(t);
  endfunction

  coef_t s_d [3];
  coef_t c_d [3];
  coef_t s_q [3];
  coef_t c_q [3];
  coef_t sr0, cr0;
  vec_t  kx_q, ky_q, kz_q;
  logic  kv_q;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      sr0 = rnd(cy[l][N]);
      cr0 = rnd(cx[l][N]);
      case (quad_q[l][N-1])
        2'd0: begin s_d[l] = sr0;  c_d[l] = cr0;  end
        2'd1: begin s_d[l] = cr0;  c_d[l] = -sr0; end
        2'd2: begin s_d[l] = -sr0; c_d[l] = -cr0; end
        default: begin s_d[l] = -cr0; c_d[l] = sr0; end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        s_q[l] <= s_d[l];
        c_q[l] <= c_d[l];
      end
      kx_q <= vx_q[N-1];
      ky_q <= vy_q[N-1];
      kz_q <= vz_q[N-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kv_q <= 1'b0;
    end else if (en) begin
      kv_q <= cv_q[N-1];
    end
  end

  // roll, pitch, yaw
  localparam int S1W = VW + 4 * CoefW;
  localparam int S2W = VW + 2 * CoefW;

  logic [S1W-1:0] side1_o;
  logic [S2W-1:0] side2_o;
  logic [VW-1:0]  side3_o;
  logic v1, v2, v3;
  vec_t y1, z1, z2, x2, x3, y3;
  coef_t sp1, cp1, sy1, cy1, sy2, cy2;
  vec_t  x1s, y2s;

  ezvr_rot_stage #(.VectorWidth(VW), .SideWidth(S1W)) u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (kv_q),
    .a_i     (ky_q),
    .b_i     (kz_q),
    .c_i     (c_q[2]),
    .s_i     (s_q[2]),
    .side_i  ({kx_q, s_q[1], c_q[1], s_q[0], c_q[0]}),
    .valid_o (v1),
    .r1_o    (y1),
    .r2_o    (z1),
    .side_o  (side1_o)
  );

  assign x1s = $signed(side1_o[S1W-1 -: VW]);
  assign sp1 = $signed(side1_o[4*CoefW-1 -: CoefW]);
  assign cp1 = $signed(side1_o[3*CoefW-1 -: CoefW]);
  assign sy1 = $signed(side1_o[2*CoefW-1 -: CoefW]);
  assign cy1 = $signed(side1_o[CoefW-1:0]);

  ezvr_rot_stage #(.VectorWidth(VW), .SideWidth(S2W)) u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v1),
    .a_i     (z1),
    .b_i     (x1s),
    .c_i     (cp1),
    .s_i     (sp1),
    .side_i  ({y1, sy1, cy1}),
    .valid_o (v2),
    .r1_o    (z2),
    .r2_o    (x2),
    .side_o  (side2_o)
  );

  assign y2s = $signed(side2_o[S2W-1 -: VW]);
  assign sy2 = $signed(side2_o[2*CoefW-1 -: CoefW]);
  assign cy2 = $signed(side2_o[CoefW-1:0]);

  ezvr_rot_stage #(.VectorWidth(VW), .SideWidth(VW)) u_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2),
    .a_i     (x2),
    .b_i     (y2s),
    .c_i     (cy2),
    .s_i     (sy2),
    .side_i  (z2),
    .valid_o (v3),
    .r1_o    (x3),
    .r2_o    (y3),
    .side_o  (side3_o)
  );

  // output register and skid
  logic o_valid_q, s_valid_q;
  logic o_valid_d, s_valid_d;
  vec_t ox_q, oy_q, oz_q, sx_q, sy_q, sz_q;
  vec_t ox_d, oy_d, oz_d, sx_d, sy_d, sz_d;
  logic incoming, take;

  assign en         = !s_valid_q;
  assign in_ready_o = en;
  assign incoming   = en && v3;
  assign take       = o_valid_q && out_ready_i;

  always_comb begin
    o_valid_d = o_valid_q;
    s_valid_d = s_valid_q;
    ox_d = ox_q; oy_d = oy_q; oz_d = oz_q;
    sx_d = sx_q; sy_d = sy_q; sz_d = sz_q;
    if (take || !o_valid_q) begin
      if (s_valid_q) begin
        o_valid_d = 1'b1;
        ox_d = sx_q; oy_d = sy_q; oz_d = sz_q;
        s_valid_d = 1'b0;
      end else begin
        o_valid_d = incoming;
        ox_d = x3; oy_d = y3; oz_d = $signed(side3_o);
      end
    end else if (incoming) begin
      s_valid_d = 1'b1;
      sx_d = x3; sy_d = y3; sz_d = $signed(side3_o);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
    end else begin
      o_valid_q <= o_valid_d;
      s_valid_q <= s_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ox_q <= ox_d; oy_q <= oy_d; oz_q <= oz_d;
    sx_q <= sx_d; sy_q <= sy_d; sz_q <= sz_d;
  end

  assign out_valid_o = o_valid_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign out_z_o     = oz_q;

`ifndef ASSERT_OFF
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_valid_q |-> o_valid_q) else $error("skid full with empty output");
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s_valid_q) |-> $past(o_valid_q && !out_ready_i))
    else $error("skid filled while output free");
  a_coef_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kv_q |-> (c_q[0] >= -32768 && c_q[0] <= 32768 && s_q[0] >= -32768 && s_q[0] <= 32768))
    else $error("coefficient out of range");
`endif

endmodule

### verif/euler_zyx_vector_rotate_checker.sv
module euler_zyx_vector_rotate_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] vec_z_i,
  input  logic signed [15:0] yaw_angle_i,
  input  logic signed [15:0] pitch_angle_i,
  input  logic signed [15:0] roll_angle_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] out_x_i,
  input  logic signed [31:0] out_y_i,
  input  logic signed [31:0] out_z_i,
  output int                 errors_o,
  output int                 pending_o
);

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec3_t;

  localparam bit [63:0] HalfPiQ62 = 64'h6487ED5110B4611A;
  localparam bit [63:0] OneQ62    = 64'h4000000000000000;

  vec3_t rotated_q[$];
  int    errors = 0;

  assign errors_o  = errors;
  assign pending_o = rotated_q.size();

  function automatic bit [63:0] mul_q62(bit [63:0] a, bit [63:0] b);
    bit [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  function automatic void sine_cosine(bit [15:0] ang, output longint s_o, output longint c_o);
    bit [127:0] p;
    bit [63:0]  x, x2, term, ssum, csum;
    longint     s, c;
    p = {64'd0, ang[13:0], 50'd0} * {64'd0, HalfPiQ62};
    x = p[127:64];
    x2 = mul_q62(x, x);
    term = x;
    ssum = x;
    for (int n = 1; n <= 14; n++) begin
      term = mul_q62(term, x2) / 64'((2 * n) * (2 * n + 1));
      ssum = n[0] ? ssum - term : ssum + term;
    end
    term = OneQ62;
    csum = OneQ62;
    for (int n = 1; n <= 14; n++) begin
      term = mul_q62(term, x2) / 64'((2 * n - 1) * (2 * n));
      csum = n[0] ? csum - term : csum + term;
    end
    s = longint'((ssum + (64'd1 << 46)) >> 47);
    c = longint'((csum + (64'd1 << 46)) >> 47);
    case (ang[15:14])
      2'd0: begin s_o = s;  c_o = c;  end
      2'd1: begin s_o = c;  c_o = -s; end
      2'd2: begin s_o = -s; c_o = -c; end
      default: begin s_o = -c; c_o = s; end
    endcase
  endfunction

  function automatic longint mix_round_sat(longint a, longint ka, longint b, longint kb);
    longint t;
    t = (ka * a + kb * b + (64'sd1 <<< 14)) >>> 15;
    if (t > 64'sd2147483647) return 64'sd2147483647;
    if (t < -64'sd2147483648) return -64'sd2147483648;
    return t;
  endfunction

  function automatic vec3_t rotate_zyx(vec3_t v, bit [15:0] yaw, bit [15:0] pitch,
                                       bit [15:0] roll);
    longint sy, cy, sp, cp, sr, cr, x, y, z, t1, t2;
    vec3_t  r;
    sine_cosine(yaw, sy, cy);
    sine_cosine(pitch, sp, cp);
    sine_cosine(roll, sr, cr);
    x = v.x;
    y = v.y;
    z = v.z;
    t1 = mix_round_sat(y, cr, z, -sr);
    t2 = mix_round_sat(y, sr, z, cr);
    y = t1; z = t2;
    t1 = mix_round_sat(x, cp, z, sp);
    t2 = mix_round_sat(x, -sp, z, cp);
    x = t1; z = t2;
    t1 = mix_round_sat(x, cy, y, -sy);
    t2 = mix_round_sat(x, sy, y, cy);
    x = t1; y = t2;
    r.x = x[31:0];
    r.y = y[31:0];
    r.z = z[31:0];
    return r;
  endfunction

  always @(posedge clk_i) begin
    vec3_t exp_v;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        rotated_q.push_back(rotate_zyx('{vec_x_i, vec_y_i, vec_z_i}, yaw_angle_i,
                                       pitch_angle_i, roll_angle_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (rotated_q.size() == 0) begin
          $display("%0t: unexpected output x=%0d y=%0d z=%0d", $time, out_x_i, out_y_i,
                   out_z_i);
          errors++;
        end else begin
          exp_v = rotated_q.pop_front();
          if (out_x_i !== exp_v.x) begin
            $display("%0t: out_x expected %0d actual %0d", $time, exp_v.x, out_x_i);
            errors++;
          end
          if (out_y_i !== exp_v.y) begin
            $display("%0t: out_y expected %0d actual %0d", $time, exp_v.y, out_y_i);
            errors++;
          end
          if (out_z_i !== exp_v.z) begin
            $display("%0t: out_z expected %0d actual %0d", $time, exp_v.z, out_z_i);
            errors++;
          end
        end
      end
    end
  end

endmodule

### verif/euler_zyx_vector_rotate_top_test.sv
module euler_zyx_vector_rotate_top_test;

  localparam int CycleLimit = 400000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] vec_x = '0;
  logic signed [31:0] vec_y = '0;
  logic signed [31:0] vec_z = '0;
  logic signed [15:0] yaw = '0;
  logic signed [15:0] pitch = '0;
  logic signed [15:0] roll = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_x, out_y, out_z;
  logic               in_fire_q = 1'b0;
  int                 errors, pending;
  int                 cycles = 0;
  int                 stall_left = 0;

  euler_zyx_vector_rotate_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .vec_x_i      (vec_x),
    .vec_y_i      (vec_y),
    .vec_z_i      (vec_z),
    .yaw_angle_i  (yaw),
    .pitch_angle_i(pitch),
    .roll_angle_i (roll),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_x_o      (out_x),
    .out_y_o      (out_y),
    .out_z_o      (out_z)
  );

  euler_zyx_vector_rotate_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .vec_x_i      (vec_x),
    .vec_y_i      (vec_y),
    .vec_z_i      (vec_z),
    .yaw_angle_i  (yaw),
    .pitch_angle_i(pitch),
    .roll_angle_i (roll),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_x_i      (out_x),
    .out_y_i      (out_y),
    .out_z_i      (out_z),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    in_fire_q <= in_valid && in_ready;
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // stretches of full throughput alternate with random stalls
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (cycles % 3000 < 600) begin
      out_ready <= 1'b1;
    end else begin
      stall_left <= gap_len();
      out_ready <= 1'b1;
    end
  end

  task automatic send_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [15:0] yw, logic [15:0] pt, logic [15:0] rl);
    int g;
    g = (cycles % 2500 < 500) ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    vec_x <= x;
    vec_y <= y;
    vec_z <= z;
    yaw <= yw;
    pitch <= pt;
    roll <= rl;
    do @(negedge clk_i); while (!in_fire_q);
  endtask

  function automatic logic [31:0] rand_component();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2 * 65536)) - 65536);
      2: return {$urandom_range(0, 1) ? 2'b01 : 2'b10, 30'($urandom())};
      3: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
    endcase
  endfunction

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 7) * 8192);
      1: return 16'($urandom_range(0, 7) * 8192 + $urandom_range(0, 2) - 1);
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    logic [15:0] angles[8];
    angles = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h7FFF, 16'h2000, 16'h0001,
               16'hFFFF};
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_vector(32'h00010000, 32'h00020000, 32'h00030000, 16'h0000, 16'h0000, 16'h0000);
    foreach (angles[i]) begin
      send_vector(32'h00010000, 32'hFFFF0000, 32'h00008000, angles[i], 16'h0000, 16'h0000);
      send_vector(32'h00010000, 32'hFFFF0000, 32'h00008000, 16'h0000, angles[i], 16'h0000);
    end
    send_vector(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h2000, 16'h2000, 16'h2000);
    send_vector(32'h80000000, 32'h80000000, 32'h80000000, 16'hE000, 16'h2000, 16'hE000);
    send_vector(32'h80000000, 32'h7FFFFFFF, 32'h00000000, 16'h8000, 16'h8000, 16'h8000);
    send_vector(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16'h4000, 16'hC000, 16'h4000);
    send_vector(32'hFFFFFFFF, 32'h00000001, 32'hFFFFFFFF, 16'h7FFF, 16'h8001, 16'h1234);
    send_vector(32'h00010000, 32'h00000000, 32'h00000000, 16'h0000, 16'h0000, 16'h4000);
    for (int i = 0; i < 850; i++) begin
      send_vector(rand_component(), rand_component(), rand_component(), rand_angle(),
                  rand_angle(), rand_angle());
    end
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### euler_zyx_vector_rotate_top.f
design/ezvr_pkg.sv
design/ezvr_cordic_cell.sv
design/ezvr_rot_stage.sv
design/euler_zyx_vector_rotate_top.sv
verif/euler_zyx_vector_rotate_checker.sv
verif/euler_zyx_vector_rotate_top_test.sv
